// ===== rtl/dtmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtmf_pkg
// Shared constants, types and functions of the DTMF tone generator: keypad
// decode, tone frequencies, register map and the quarter-wave sine builder.
// ----------------------------------------------------------------------------
package dtmf_pkg;

	// default parameter values
	localparam int QUEUE_DEPTH_DEF  = 16;
	localparam int SINE_BITS_DEF    = 10;
	localparam int SAMPLE_WIDTH_DEF = 16;

	// fixed field widths
	localparam int LEN_W   = 16;
	localparam int GAIN_W  = 15;
	localparam int SCALE_W = 21;
	localparam int PHASE_W = 32;
	localparam int CODE_W  = 4;
	localparam int FREQ_W  = 11;
	localparam int LEVEL_W = 5;
	localparam int CHAR_W  = 8;

	// configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// register reset values
	localparam logic [LEN_W-1:0]   TONE_SAMPLES_RST = 16'd800;
	localparam logic [LEN_W-1:0]   GAP_SAMPLES_RST  = 16'd400;
	localparam logic [GAIN_W-1:0]  GAIN_RST         = 15'd16384;
	localparam logic [SCALE_W-1:0] PHASE_SCALE_RST  = 21'd536871;

	// output buffer
	localparam int OUT_FIFO_DEPTH = 8;
	localparam int PEND_W         = 2;

	// register indexes, byte address 4*index
	typedef enum logic [1:0] {
		REG_TONE_SAMPLES = 2'd0,
		REG_GAP_SAMPLES  = 2'd1,
		REG_GAIN         = 2'd2,
		REG_PHASE_SCALE  = 2'd3
	} reg_idx_t;

	// per-tick control result handed from the sequencer to the synthesizer
	typedef struct packed {
		logic               tone_on;
		logic               gap_on;
		logic               start_tone;
		logic               all_sent;
		logic               dropped;
		logic [LEVEL_W-1:0] level;
	} tick_t;

	typedef struct packed {
		logic              ok;
		logic [CODE_W-1:0] code;
	} key_t;

	// keypad character to row*4+col code
	function automatic key_t decode_key(logic [CHAR_W-1:0] c);
		key_t k;
		k.ok = 1'b1;
		case (c)
			8'h31:   k.code = 4'd0;   // 1
			8'h32:   k.code = 4'd1;   // 2
			8'h33:   k.code = 4'd2;   // 3
			8'h41:   k.code = 4'd3;   // A
			8'h34:   k.code = 4'd4;   // 4
			8'h35:   k.code = 4'd5;   // 5
			8'h36:   k.code = 4'd6;   // 6
			8'h42:   k.code = 4'd7;   // B
			8'h37:   k.code = 4'd8;   // 7
			8'h38:   k.code = 4'd9;   // 8
			8'h39:   k.code = 4'd10;  // 9
			8'h43:   k.code = 4'd11;  // C
			8'h2A:   k.code = 4'd12;  // *
			8'h30:   k.code = 4'd13;  // 0
			8'h23:   k.code = 4'd14;  // #
			8'h44:   k.code = 4'd15;  // D
			default: begin
				k.ok   = 1'b0;
				k.code = 4'd0;
			end
		endcase
		return k;
	endfunction

	// low group frequencies in hertz
	function automatic logic [FREQ_W-1:0] row_freq(logic [1:0] r);
		logic [FREQ_W-1:0] f;
		case (r)
			2'd0:    f = 11'd697;
			2'd1:    f = 11'd770;
			2'd2:    f = 11'd852;
			default: f = 11'd941;
		endcase
		return f;
	endfunction

	// high group frequencies in hertz
	function automatic logic [FREQ_W-1:0] col_freq(logic [1:0] c);
		logic [FREQ_W-1:0] f;
		case (c)
			2'd0:    f = 11'd1209;
			2'd1:    f = 11'd1336;
			2'd2:    f = 11'd1477;
			default: f = 11'd1633;
		endcase
		return f;
	endfunction

	// quarter-wave sine entry, polynomial in q16, evaluated at elaboration
	function automatic int unsigned quarter_sine(int unsigned m, int unsigned tbits,
			int unsigned sw);
		longint unsigned pk;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned p;
		longint unsigned s;
		longint unsigned v;
		pk = (64'd1 << (sw - 1)) - 64'd1;
		x  = 64'(m) << (18 - tbits);
		x2 = (x * x) >> 16;
		p  = 64'd307;
		p  = 64'd5223 - ((p * x2) >> 16);
		p  = 64'd42334 - ((p * x2) >> 16);
		p  = 64'd102944 - ((p * x2) >> 16);
		s  = (p * x) >> 16;
		v  = (s * pk + 64'd32768) >> 16;
		if (v > pk) begin
			v = pk;
		end
		return 32'(v);
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dtmf_tone_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtmf_tone_generator
// DTMF tone generator, one output sample per input transaction.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (in_valid/in_stall): one transaction per sample tick; it
//    may carry a keypad character (digit_valid, digit_char) to queue.
//  - output channel (out_valid/out_stall): one result per input transaction,
//    in order: sample, tone_on, gap_on, all_sent, digit_dropped, queue_level.
//  - apb port: tone_samples at 0x0, gap_samples at 0x4, gain at 0x8,
//    phase_scale at 0xC; write only while no transaction is outstanding.
//  - a result passes stages 1 to 3 and the output buffer before it is offered.
//  - throughput: one transaction per cycle while in_stall is low; the
//    sequencer updates the queue RAM and segment state on each accepted
//    transaction, and the sample path is a 3-stage pipeline behind it.
//  - the output is buffered 8 deep; when the receiver stalls, in_stall rises
//    once buffered plus in-flight results reach that depth, and results
//    already offered hold steady.
//  - reset empties the queue and buffer and restores register defaults;
//    no gap precedes the first digit after reset.
// ----------------------------------------------------------------------------
module dtmf_tone_generator #(
	parameter int QUEUE_DEPTH     = dtmf_pkg::QUEUE_DEPTH_DEF,
	parameter int SINE_TABLE_BITS = dtmf_pkg::SINE_BITS_DEF,
	parameter int SAMPLE_WIDTH    = dtmf_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// input channel
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         digit_valid,
	input  wire logic [dtmf_pkg::CHAR_W-1:0]  digit_char,
	// output channel
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [SAMPLE_WIDTH-1:0]      sample,
	output logic                              tone_on,
	output logic                              gap_on,
	output logic                              all_sent,
	output logic                              digit_dropped,
	output logic      [dtmf_pkg::LEVEL_W-1:0] queue_level,
	// configuration
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dtmf_pkg::APB_AW-1:0]  paddr,
	input  wire logic [dtmf_pkg::APB_DW-1:0]  pwdata,
	output logic      [dtmf_pkg::APB_DW-1:0]  prdata,
	output logic                              pready
);
	import dtmf_pkg::*;

	localparam int RES_W = SAMPLE_WIDTH + 4 + LEVEL_W;

	logic [LEN_W-1:0]        tone_samples_q;
	logic [LEN_W-1:0]        gap_samples_q;
	logic [GAIN_W-1:0]       gain_q;
	logic [SCALE_W-1:0]      phase_scale_q;
	reg_idx_t                reg_idx;
	logic                    cfg_wr;
	logic                    accept;

	logic                    v_s1;
	tick_t                   tick_s1;
	logic [CODE_W-1:0]       code_s1;
	logic                    v_s2;
	logic                    v_s3;
	tick_t                   tick_s3;
	logic [SAMPLE_WIDTH-1:0] sample_s3;
	logic [PEND_W-1:0]       pend;
	logic [RES_W-1:0]        res_in;
	logic [RES_W-1:0]        res_out;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign accept  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_samples_q <= TONE_SAMPLES_RST;
			gap_samples_q  <= GAP_SAMPLES_RST;
			gain_q         <= GAIN_RST;
			phase_scale_q  <= PHASE_SCALE_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_TONE_SAMPLES: tone_samples_q <= pwdata[LEN_W-1:0];
				REG_GAP_SAMPLES:  gap_samples_q  <= pwdata[LEN_W-1:0];
				REG_GAIN:         gain_q         <= pwdata[GAIN_W-1:0];
				REG_PHASE_SCALE:  phase_scale_q  <= pwdata[SCALE_W-1:0];
				default:          ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_TONE_SAMPLES: prdata = APB_DW'(tone_samples_q);
			REG_GAP_SAMPLES:  prdata = APB_DW'(gap_samples_q);
			REG_GAIN:         prdata = APB_DW'(gain_q);
			REG_PHASE_SCALE:  prdata = APB_DW'(phase_scale_q);
			default:          prdata = '0;
		endcase
	end

	// queue and segment sequencer
	dtmf_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.digit_valid  (digit_valid),
		.digit_char   (digit_char),
		.tone_samples (tone_samples_q),
		.gap_samples  (gap_samples_q),
		.v_s1         (v_s1),
		.tick_s1      (tick_s1),
		.code_s1      (code_s1)
	);

	// sample datapath
	dtmf_synth #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS),
		.SAMPLE_WIDTH    (SAMPLE_WIDTH)
	) u_synth (
		.clk         (clk),
		.arst_n      (arst_n),
		.v_s1        (v_s1),
		.tick_s1     (tick_s1),
		.code_s1     (code_s1),
		.gain        (gain_q),
		.phase_scale (phase_scale_q),
		.v_s2        (v_s2),
		.v_s3        (v_s3),
		.tick_s3     (tick_s3),
		.sample_s3   (sample_s3)
	);

	// transactions still in the pipeline
	assign pend = PEND_W'(v_s1) + PEND_W'(v_s2) + PEND_W'(v_s3);

	assign res_in = {sample_s3, tick_s3.tone_on, tick_s3.gap_on, tick_s3.all_sent,
		tick_s3.dropped, tick_s3.level};

	// result buffer
	dtmf_out_fifo #(
		.WIDTH (RES_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s3),
		.push_data (res_in),
		.pend      (pend),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (res_out),
		.in_stall  (in_stall)
	);

	assign {sample, tone_on, gap_on, all_sent, digit_dropped, queue_level} = res_out;

endmodule
`default_nettype wire

// ===== rtl/dtmf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtmf_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered (old data on a same-address write).
// ----------------------------------------------------------------------------
module dtmf_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/dtmf_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtmf_ctrl
// Digit queue and segment sequencer. Queues keypad codes in a RAM, plays
// tones and gaps, and hands one control word per transaction to stage 1
// together with the dequeued code read from the queue RAM.
// ----------------------------------------------------------------------------
module dtmf_ctrl #(
	parameter int QUEUE_DEPTH = dtmf_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          digit_valid,
	input  wire logic [dtmf_pkg::CHAR_W-1:0]   digit_char,
	input  wire logic [dtmf_pkg::LEN_W-1:0]    tone_samples,
	input  wire logic [dtmf_pkg::LEN_W-1:0]    gap_samples,
	output logic                               v_s1,
	output dtmf_pkg::tick_t                    tick_s1,
	output logic      [dtmf_pkg::CODE_W-1:0]   code_s1
);
	import dtmf_pkg::*;

	localparam int QAW = $clog2(QUEUE_DEPTH);
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	logic [QAW-1:0]    rd_ptr_q;
	logic [QAW-1:0]    wr_ptr_q;
	logic [QCW-1:0]    count_q;
	logic [LEN_W-1:0]  seg_pos_q;
	logic [LEN_W-1:0]  seg_len_q;
	logic              tone_q;
	logic              gap_q;
	logic              owed_q;

	key_t              key;
	logic              full;
	logic              enq;
	logic              dropped;
	logic [QCW-1:0]    count_a;
	logic [QCW-1:0]    count_n;
	logic              idle;
	logic              start;
	logic              start_gap;
	logic              start_tone;
	logic              tone_now;
	logic              gap_now;
	logic [LEN_W-1:0]  len_cfg;
	logic [LEN_W-1:0]  len_min;
	logic [LEN_W-1:0]  len_cur;
	logic [LEN_W-1:0]  pos_cur;
	logic [LEN_W:0]    pos_inc;
	logic              seg_end;
	logic              owed_n;
	logic              all_sent;
	tick_t             tick;
	logic [CODE_W-1:0] ram_rdata;
	logic              byp_s1;
	logic [CODE_W-1:0] byp_code_s1;

	// enqueue, then segment start, then sample position advance
	always_comb begin
		key        = decode_key(digit_char);
		full       = (count_q == QCW'(QUEUE_DEPTH));
		enq        = digit_valid && key.ok && !full;
		dropped    = digit_valid && !enq;
		count_a    = count_q + QCW'(enq);
		idle       = !tone_q && !gap_q;
		start      = idle && (count_a != '0);
		start_gap  = start && owed_q;
		start_tone = start && !owed_q;
		count_n    = count_a - QCW'(start_tone);
		tone_now   = tone_q || start_tone;
		gap_now    = gap_q || start_gap;
		len_cfg    = owed_q ? gap_samples : tone_samples;
		len_min    = (len_cfg == '0) ? LEN_W'(1) : len_cfg;
		len_cur    = start ? len_min : seg_len_q;
		pos_cur    = start ? '0 : seg_pos_q;
		pos_inc    = {1'b0, pos_cur} + (LEN_W + 1)'(1);
		seg_end    = (tone_now || gap_now) && (pos_inc >= {1'b0, len_cur});
		all_sent   = seg_end && (count_n == '0);
		if (seg_end && tone_now) begin
			owed_n = 1'b1;
		end else if (start_gap) begin
			owed_n = 1'b0;
		end else begin
			owed_n = owed_q;
		end
		tick.tone_on    = tone_now;
		tick.gap_on     = gap_now;
		tick.start_tone = start_tone;
		tick.all_sent   = all_sent;
		tick.dropped    = dropped;
		tick.level      = LEVEL_W'(count_n);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			count_q   <= '0;
			seg_pos_q <= '0;
			seg_len_q <= '0;
			tone_q    <= 1'b0;
			gap_q     <= 1'b0;
			owed_q    <= 1'b0;
		end else if (accept) begin
			if (enq) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QAW'(1);
			end
			if (start_tone) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QAW'(1);
			end
			count_q   <= count_n;
			seg_len_q <= len_cur;
			seg_pos_q <= pos_inc[LEN_W-1:0];
			owed_q    <= owed_n;
			tone_q    <= tone_now && !seg_end;
			gap_q     <= gap_now && !seg_end;
		end
	end

	// digit queue storage
	dtmf_ram #(
		.WIDTH (CODE_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (accept && enq),
		.waddr (wr_ptr_q),
		.wdata (key.code),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	// stage 1 payload, with forwarding of a code written and read in the same cycle
	always_ff @(posedge clk) begin
		byp_s1      <= accept && enq && (wr_ptr_q == rd_ptr_q);
		byp_code_s1 <= key.code;
		if (accept) begin
			tick_s1 <= tick;
		end
	end

	assign code_s1 = byp_s1 ? byp_code_s1 : ram_rdata;

	// tone and gap are exclusive
	assert property (@(posedge clk) disable iff (!arst_n) !(tone_q && gap_q))
		else $error("tone and gap active together");

	// a tone always leaves a gap owed behind it
	assert property (@(posedge clk) disable iff (!arst_n) $fell(tone_q) |-> owed_q)
		else $error("tone ended without owing a gap");

	// a gap only starts when a digit waits behind it
	assert property (@(posedge clk) disable iff (!arst_n) $rose(gap_q) |-> (count_q != '0))
		else $error("gap started with an empty queue");

endmodule
`default_nettype wire

// ===== rtl/dtmf_synth.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtmf_synth
// Sample datapath: phase accumulators (stage 1), quarter-wave table lookup
// (stage 2), gain multiply (stage 3), rounding, sum and saturation.
// ----------------------------------------------------------------------------
module dtmf_synth #(
	parameter int SINE_TABLE_BITS = dtmf_pkg::SINE_BITS_DEF,
	parameter int SAMPLE_WIDTH    = dtmf_pkg::SAMPLE_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          v_s1,
	input  wire dtmf_pkg::tick_t               tick_s1,
	input  wire logic [dtmf_pkg::CODE_W-1:0]   code_s1,
	input  wire logic [dtmf_pkg::GAIN_W-1:0]   gain,
	input  wire logic [dtmf_pkg::SCALE_W-1:0]  phase_scale,
	output logic                               v_s2,
	output logic                               v_s3,
	output dtmf_pkg::tick_t                    tick_s3,
	output logic      [SAMPLE_WIDTH-1:0]       sample_s3
);
	import dtmf_pkg::*;

	localparam int SB = SINE_TABLE_BITS;
	localparam int QN = 1 << (SB - 2);
	localparam int IW = SB - 1;
	localparam int MW = SAMPLE_WIDTH - 1;
	localparam int PW = MW + GAIN_W;
	localparam int SW = SAMPLE_WIDTH + 1;

	logic [MW-1:0]      qtab [QN+1];
	logic [PHASE_W-1:0] row_phase_q;
	logic [PHASE_W-1:0] col_phase_q;
	logic [PHASE_W-1:0] row_step_q;
	logic [PHASE_W-1:0] col_step_q;
	logic [PHASE_W-1:0] row_mult;
	logic [PHASE_W-1:0] col_mult;
	logic [PHASE_W-1:0] row_used;
	logic [PHASE_W-1:0] col_used;
	logic [SB-1:0]      row_k;
	logic [SB-1:0]      col_k;
	logic [IW-1:0]      row_idx;
	logic [IW-1:0]      col_idx;

	logic [MW-1:0]      row_mag_s2;
	logic [MW-1:0]      col_mag_s2;
	logic               row_neg_s2;
	logic               col_neg_s2;
	tick_t              tick_s2;

	logic [PW-1:0]      row_prod_s3;
	logic [PW-1:0]      col_prod_s3;
	logic               row_neg_s3;
	logic               col_neg_s3;

	logic [PW:0]        row_rnd;
	logic [PW:0]        col_rnd;
	logic signed [SW-1:0] row_term;
	logic signed [SW-1:0] col_term;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] peak;
	logic signed [SW-1:0] sat;

	// quarter-wave sine table, constant
	for (genvar g = 0; g <= QN; g++) begin : g_tab
		assign qtab[g] = MW'(quarter_sine(g, SINE_TABLE_BITS, SAMPLE_WIDTH));
	end

	// stage 1: step multiply on a new tone, phase select and table index
	always_comb begin
		row_mult = PHASE_W'(row_freq(code_s1[3:2])) * PHASE_W'(phase_scale);
		col_mult = PHASE_W'(col_freq(code_s1[1:0])) * PHASE_W'(phase_scale);
		row_used = tick_s1.start_tone ? '0 : row_phase_q;
		col_used = tick_s1.start_tone ? '0 : col_phase_q;
		row_k    = row_used[PHASE_W-1 -: SB];
		col_k    = col_used[PHASE_W-1 -: SB];
		row_idx  = row_k[SB-2] ? IW'(QN) - IW'(row_k[SB-3:0]) : IW'(row_k[SB-3:0]);
		col_idx  = col_k[SB-2] ? IW'(QN) - IW'(col_k[SB-3:0]) : IW'(col_k[SB-3:0]);
	end

	// phase accumulators, restarted at zero with each tone
	always_ff @(posedge clk) begin
		if (v_s1 && tick_s1.tone_on) begin
			if (tick_s1.start_tone) begin
				row_step_q  <= row_mult;
				col_step_q  <= col_mult;
				row_phase_q <= row_mult;
				col_phase_q <= col_mult;
			end else begin
				row_phase_q <= row_phase_q + row_step_q;
				col_phase_q <= col_phase_q + col_step_q;
			end
		end
	end

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 2 table read, stage 3 gain products
	always_ff @(posedge clk) begin
		row_mag_s2  <= qtab[row_idx];
		col_mag_s2  <= qtab[col_idx];
		row_neg_s2  <= row_k[SB-1];
		col_neg_s2  <= col_k[SB-1];
		tick_s2     <= tick_s1;
		row_prod_s3 <= PW'(row_mag_s2) * PW'(gain);
		col_prod_s3 <= PW'(col_mag_s2) * PW'(gain);
		row_neg_s3  <= row_neg_s2;
		col_neg_s3  <= col_neg_s2;
		tick_s3     <= tick_s2;
	end

	// round, restore sign, sum and saturate
	always_comb begin
		row_rnd  = {1'b0, row_prod_s3} + (PW + 1)'(16384);
		col_rnd  = {1'b0, col_prod_s3} + (PW + 1)'(16384);
		row_term = $signed({2'b00, row_rnd[15 +: MW]});
		col_term = $signed({2'b00, col_rnd[15 +: MW]});
		if (row_neg_s3) begin
			row_term = -row_term;
		end
		if (col_neg_s3) begin
			col_term = -col_term;
		end
		sum  = row_term + col_term;
		peak = $signed({2'b00, {MW{1'b1}}});
		if (sum > peak) begin
			sat = peak;
		end else if (sum < -peak) begin
			sat = -peak;
		end else begin
			sat = sum;
		end
		sample_s3 = tick_s3.tone_on ? sat[SAMPLE_WIDTH-1:0] : '0;
	end

endmodule
`default_nettype wire

// ===== rtl/dtmf_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtmf_out_fifo
// Result buffer between the pipeline and the output channel. Input stall is
// taken from the buffer fill plus the transactions still in the pipeline, so
// a full pipeline always has room to drain.
// ----------------------------------------------------------------------------
module dtmf_out_fifo #(
	parameter int WIDTH = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic [WIDTH-1:0]            push_data,
	input  wire logic [dtmf_pkg::PEND_W-1:0] pend,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic      [WIDTH-1:0]            out_data,
	output logic                             in_stall
);
	import dtmf_pkg::*;

	localparam int DEPTH = OUT_FIFO_DEPTH;
	localparam int FAW   = $clog2(DEPTH);
	localparam int FCW   = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [FAW-1:0]   wr_ptr_q;
	logic [FAW-1:0]   rd_ptr_q;
	logic [FCW-1:0]   count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && !out_stall;
	assign in_stall  = ((FCW + 1)'(count_q) + (FCW + 1)'(pend)) >= (FCW + 1)'(DEPTH);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FAW'(1);
			end
			count_q <= count_q + FCW'(push) - FCW'(pop);
		end
	end

	// no push into a full buffer
	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (count_q == FCW'(DEPTH))))
		else $error("result buffer overflow");

	// fill never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FCW'(DEPTH))
		else $error("result buffer fill out of range");

endmodule
`default_nettype wire
